// ----- sv/w2s_pkg.sv -----
// ----------------------------------------------------------------------------
// w2s_pkg
// Shared types and constants for the world-to-screen projection pipeline.
// ----------------------------------------------------------------------------
package w2s_pkg;

  localparam int unsigned COEF_W = 32;
  localparam int unsigned PROD_W = 64;
  // clip values: sum of three products plus offset, kept wide enough for all
  localparam int unsigned CLIP_W = 66;
  localparam int unsigned VP_W   = 14;
  localparam int unsigned ADDR_W = 6;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned NUM_ROWS  = 3;
  localparam int unsigned NUM_TERMS = 4;

  typedef enum logic [2:0] {
    REG_X_LO  = 3'd0,
    REG_X_HI  = 3'd1,
    REG_Y_LO  = 3'd2,
    REG_Y_HI  = 3'd3,
    REG_W_LO  = 3'd4,
    REG_W_HI  = 3'd5,
    REG_VP_W  = 3'd6,
    REG_VP_H  = 3'd7
  } w2s_reg_e;

  // row order: clip x, clip y, w; term order: x, y, z, offset
  typedef struct packed {
    logic [NUM_ROWS-1:0][NUM_TERMS-1:0][COEF_W-1:0] coef;
    logic [VP_W-1:0]                               vp_w;
    logic [VP_W-1:0]                               vp_h;
  } w2s_cfg_t;

  // flags that travel beside the divider lanes
  typedef struct packed {
    logic valid;
    logic ok;
    logic neg_x;
    logic neg_y;
  } w2s_side_t;

endpackage

// ----- sv/w2s_cfg.sv -----
// ----------------------------------------------------------------------------
// w2s_cfg
// APB-style register file holding the matrix rows and viewport size.
// ----------------------------------------------------------------------------
module w2s_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [w2s_pkg::ADDR_W-1:0]   paddr,
  input  logic [w2s_pkg::DATA_W-1:0]   pwdata,
  output logic [w2s_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output w2s_pkg::w2s_cfg_t            cfg_o
);

  logic [5:0][w2s_pkg::DATA_W-1:0] row_q;
  logic [w2s_pkg::VP_W-1:0]        vp_w_q, vp_h_q;
  logic                            wr_en;
  w2s_pkg::w2s_reg_e               idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = w2s_pkg::w2s_reg_e'(paddr[5:3]);

  // Write registers on the access cycle of a transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= 64'd65536;
      row_q[1] <= 64'd0;
      row_q[2] <= 64'd281474976710656;
      row_q[3] <= 64'd0;
      row_q[4] <= 64'd0;
      row_q[5] <= 64'd281474976710656;
      vp_w_q   <= 14'd640;
      vp_h_q   <= 14'd480;
    end else if (wr_en) begin
      unique case (idx)
        w2s_pkg::REG_X_LO: row_q[0] <= pwdata;
        w2s_pkg::REG_X_HI: row_q[1] <= pwdata;
        w2s_pkg::REG_Y_LO: row_q[2] <= pwdata;
        w2s_pkg::REG_Y_HI: row_q[3] <= pwdata;
        w2s_pkg::REG_W_LO: row_q[4] <= pwdata;
        w2s_pkg::REG_W_HI: row_q[5] <= pwdata;
        w2s_pkg::REG_VP_W: vp_w_q   <= pwdata[w2s_pkg::VP_W-1:0];
        w2s_pkg::REG_VP_H: vp_h_q   <= pwdata[w2s_pkg::VP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      w2s_pkg::REG_X_LO: prdata = row_q[0];
      w2s_pkg::REG_X_HI: prdata = row_q[1];
      w2s_pkg::REG_Y_LO: prdata = row_q[2];
      w2s_pkg::REG_Y_HI: prdata = row_q[3];
      w2s_pkg::REG_W_LO: prdata = row_q[4];
      w2s_pkg::REG_W_HI: prdata = row_q[5];
      w2s_pkg::REG_VP_W: prdata = {{(w2s_pkg::DATA_W-w2s_pkg::VP_W){1'b0}}, vp_w_q};
      w2s_pkg::REG_VP_H: prdata = {{(w2s_pkg::DATA_W-w2s_pkg::VP_W){1'b0}}, vp_h_q};
      default:           prdata = '0;
    endcase
  end

  // Unpack rows into coefficient fields
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      cfg_o.coef[r][0] = row_q[2*r][31:0];
      cfg_o.coef[r][1] = row_q[2*r][63:32];
      cfg_o.coef[r][2] = row_q[2*r+1][31:0];
      cfg_o.coef[r][3] = row_q[2*r+1][63:32];
    end
    cfg_o.vp_w = vp_w_q;
    cfg_o.vp_h = vp_h_q;
  end

endmodule

// ----- sv/w2s_dot.sv -----
// ----------------------------------------------------------------------------
// w2s_dot
// Three-stage matrix row evaluation: products, sums, floor shift plus offset.
// ----------------------------------------------------------------------------
module w2s_dot #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  input  logic signed [w2s_pkg::COEF_W-1:0]       point_x_i,
  input  logic signed [w2s_pkg::COEF_W-1:0]       point_y_i,
  input  logic signed [w2s_pkg::COEF_W-1:0]       point_z_i,
  input  w2s_pkg::w2s_cfg_t                       cfg_i,
  output logic                                    valid_o,
  output logic signed [2:0][w2s_pkg::CLIP_W-1:0]  clip_o
);

  logic signed [2:0][2:0][w2s_pkg::PROD_W-1:0] prod_d, prod_q;
  logic signed [2:0][w2s_pkg::CLIP_W-1:0]      sum_d, sum_q, clip_d, clip_q;
  logic [2:0]                                  vld_q;

  // Form the nine exact products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod_d[r][0] = $signed(cfg_i.coef[r][0]) * point_x_i;
      prod_d[r][1] = $signed(cfg_i.coef[r][1]) * point_y_i;
      prod_d[r][2] = $signed(cfg_i.coef[r][2]) * point_z_i;
    end
  end

  // Sum products exactly, then floor shift and add the offset
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = w2s_pkg::CLIP_W'($signed(prod_q[r][0]))
               + w2s_pkg::CLIP_W'($signed(prod_q[r][1]))
               + w2s_pkg::CLIP_W'($signed(prod_q[r][2]));
      clip_d[r] = ($signed(sum_q[r]) >>> FRAC_BITS)
                + w2s_pkg::CLIP_W'($signed(cfg_i.coef[r][3]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= sum_d;
    clip_q <= clip_d;
  end

  assign valid_o = vld_q[2];
  assign clip_o  = clip_q;

endmodule

// ----- sv/w2s_div.sv -----
// ----------------------------------------------------------------------------
// w2s_div
// Pipelined restoring divider, one quotient bit per stage, for |c| < w.
// ----------------------------------------------------------------------------
module w2s_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic [w2s_pkg::CLIP_W-1:0]   num_i,
  input  logic [w2s_pkg::CLIP_W-1:0]   den_i,
  output logic [FRAC_BITS-1:0]         quo_o
);

  localparam int unsigned CW = w2s_pkg::CLIP_W;

  logic [FRAC_BITS-1:0][CW-1:0]        rem_in, den_in, rem_q, den_q;
  logic [FRAC_BITS-1:0][FRAC_BITS-1:0] quo_in, quo_q;
  logic [FRAC_BITS-1:0][CW:0]          nxt;

  // shift, compare and subtract; top bit is the quotient bit
  function automatic logic [CW:0] div_step(logic [CW-1:0] rem, logic [CW-1:0] den);
    logic [CW:0] shl;
    shl = {rem, 1'b0};
    if (shl >= {1'b0, den}) begin
      return {1'b1, CW'(shl - {1'b0, den})};
    end
    return {1'b0, CW'(shl)};
  endfunction

  // Feed each stage from the one before
  always_comb begin
    rem_in[0] = num_i;
    den_in[0] = den_i;
    quo_in[0] = '0;
    for (int k = 1; k < int'(FRAC_BITS); k++) begin
      rem_in[k] = rem_q[k-1];
      den_in[k] = den_q[k-1];
      quo_in[k] = quo_q[k-1];
    end
    for (int k = 0; k < int'(FRAC_BITS); k++) begin
      nxt[k] = div_step(rem_in[k], den_in[k]);
    end
  end

  // Advance every stage by one step
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < int'(FRAC_BITS); k++) begin
      rem_q[k] <= nxt[k][CW-1:0];
      den_q[k] <= den_in[k];
      quo_q[k] <= {quo_in[k][FRAC_BITS-2:0], nxt[k][CW]};
    end
  end

  assign quo_o = quo_q[FRAC_BITS-1];

endmodule

// ----- sv/w2s_out.sv -----
// ----------------------------------------------------------------------------
// w2s_out
// Viewport mapping with saturation and the output register.
// ----------------------------------------------------------------------------
module w2s_out #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  w2s_pkg::w2s_side_t      side_i,
  input  logic [FRAC_BITS-1:0]    quo_x_i,
  input  logic [FRAC_BITS-1:0]    quo_y_i,
  input  w2s_pkg::w2s_cfg_t       cfg_i,
  output logic                    done_o,
  output logic                    on_screen_o,
  output logic signed [31:0]      screen_x_o,
  output logic signed [31:0]      screen_y_o
);

  localparam int unsigned TW = FRAC_BITS + 1;
  localparam int unsigned HW = w2s_pkg::VP_W - 1;
  localparam int unsigned PW = TW + HW;
  localparam int unsigned EW = PW + 32;

  logic [TW-1:0]   one, tx, ty;
  logic [HW-1:0]   hw, hh;
  logic [PW-1:0]   px, py;
  logic [31:0]     sx_d, sy_d;
  logic            done_q, on_q;
  logic [31:0]     sx_q, sy_q;

  assign one = TW'(1) << FRAC_BITS;
  assign hw  = cfg_i.vp_w[w2s_pkg::VP_W-1:1];
  assign hh  = cfg_i.vp_h[w2s_pkg::VP_W-1:1];

  // x grows with the ratio, y is flipped
  assign tx = side_i.neg_x ? one - TW'(quo_x_i) : one + TW'(quo_x_i);
  assign ty = side_i.neg_y ? one + TW'(quo_y_i) : one - TW'(quo_y_i);
  assign px = PW'(hw) * PW'(tx);
  assign py = PW'(hh) * PW'(ty);

  // Saturate at the top of the signed range; values are never negative
  assign sx_d = (EW'(px) > EW'(32'h7fff_ffff)) ? 32'h7fff_ffff : 32'(EW'(px));
  assign sy_d = (EW'(py) > EW'(32'h7fff_ffff)) ? 32'h7fff_ffff : 32'(EW'(py));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= side_i.valid;
    end
  end

  // Drop coordinates for points off screen
  always_ff @(posedge clk_i) begin
    on_q <= side_i.ok;
    sx_q <= side_i.ok ? sx_d : 32'd0;
    sy_q <= side_i.ok ? sy_d : 32'd0;
  end

  assign done_o      = done_q;
  assign on_screen_o = on_q;
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;

endmodule

// ----- sv/world_to_screen_projection_top.sv -----
// ----------------------------------------------------------------------------
// world_to_screen_projection_top
// Perspective projection of one fixed-point point per cycle to pixel space.
//
//   channel   signals                                   transfer when
//   input     start_i, point_x_i/_y_i/_z_i, busy_o      start_i & !busy_o
//   result    done_o, on_screen_o, screen_x_o/_y_o      done_o (one cycle)
//   config    psel, penable, pwrite, paddr, pwdata      psel&penable&pwrite
//
// A point is taken every cycle; busy_o stays low. Each result passes
// through three row stages, one inside test stage, one divider stage per
// quotient bit and one output stage.
// Reset clears the valid line and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module world_to_screen_projection_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic signed [31:0]          point_x_i,
  input  logic signed [31:0]          point_y_i,
  input  logic signed [31:0]          point_z_i,
  output logic                        done_o,
  output logic                        on_screen_o,
  output logic signed [31:0]          screen_x_o,
  output logic signed [31:0]          screen_y_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [w2s_pkg::ADDR_W-1:0]  paddr,
  input  logic [w2s_pkg::DATA_W-1:0]  pwdata,
  output logic [w2s_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned CW = w2s_pkg::CLIP_W;

  w2s_pkg::w2s_cfg_t              cfg;
  logic                           dot_vld;
  logic signed [2:0][CW-1:0]      clip;
  logic [CW-1:0]                  ax_d, ay_d, ax_q, ay_q, w_q;
  logic                           ok_d;
  w2s_pkg::w2s_side_t             side_d;
  w2s_pkg::w2s_side_t [FRAC_BITS:0] side_q;
  logic [FRAC_BITS-1:0]           quo_x, quo_y;

  assign busy_o = 1'b0;

  w2s_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  w2s_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
    .clk_i, .rst_ni,
    .valid_i   (start_i & ~busy_o),
    .point_x_i, .point_y_i, .point_z_i,
    .cfg_i     (cfg),
    .valid_o   (dot_vld),
    .clip_o    (clip)
  );

  // Take magnitudes and test the point against the frustum
  assign ax_d = clip[0][CW-1] ? CW'(-clip[0]) : CW'(clip[0]);
  assign ay_d = clip[1][CW-1] ? CW'(-clip[1]) : CW'(clip[1]);
  assign ok_d = !clip[2][CW-1] && (clip[2] != '0)
              && (ax_d < CW'(clip[2])) && (ay_d < CW'(clip[2]));

  assign side_d.valid = dot_vld;
  assign side_d.ok    = ok_d;
  assign side_d.neg_x = clip[0][CW-1];
  assign side_d.neg_y = clip[1][CW-1];

  // Advance flags alongside the divider stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else begin
      side_q[0] <= side_d;
      for (int k = 0; k < int'(FRAC_BITS); k++) begin
        side_q[k+1] <= side_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= ax_d;
    ay_q <= ay_d;
    w_q  <= CW'(clip[2]);
  end

  w2s_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i, .num_i (ax_q), .den_i (w_q), .quo_o (quo_x)
  );

  w2s_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i, .num_i (ay_q), .den_i (w_q), .quo_o (quo_y)
  );

  w2s_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk_i, .rst_ni,
    .side_i  (side_q[FRAC_BITS]),
    .quo_x_i (quo_x),
    .quo_y_i (quo_y),
    .cfg_i   (cfg),
    .done_o, .on_screen_o, .screen_x_o, .screen_y_o
  );

endmodule
